// File: hdl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared fixed-point types and constants for the haversine distance pipeline.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int unsigned CordicW    = 34;
  localparam int unsigned SqrtSteps  = 31;

  typedef logic signed [CordicW-1:0] cordic_t;
  typedef logic signed [31:0]        unit_t;

  typedef struct packed {
    logic [30:0] root;
    logic [33:0] rem;
  } sqrt_t;

  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] RECIP_TURN   = 32'd3202559735;
  localparam logic [30:0] ONE_Q30      = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam cordic_t     UNIT_POS     = 34'sd1073741824;
  localparam cordic_t     UNIT_NEG     = -34'sd1073741824;
  localparam cordic_t     GAIN_Q30     = 34'sd652032874;
  localparam cordic_t     HALF_PI_C    = 34'sd1686629713;
  localparam logic [28:0] FULL_TURN    = 29'd360000000;
  localparam logic [28:0] HALF_TURN    = 29'd180000000;
  localparam logic [28:0] QUARTER_TURN = 29'd90000000;
  localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;
  localparam logic [24:0] DISTANCE_MAX = 25'd20015087;

  function automatic cordic_t atan_q30(int unsigned i);
    cordic_t t;
    case (i)
      0: t = 34'sd843314856;
      1: t = 34'sd497837829;
      2: t = 34'sd263043836;
      3: t = 34'sd133525158;
      4: t = 34'sd67021686;
      5: t = 34'sd33543515;
      6: t = 34'sd16775850;
      7: t = 34'sd8388437;
      8: t = 34'sd4194282;
      9: t = 34'sd2097149;
      default: begin
        if (i <= 30) begin
          t = cordic_t'((64'd1 << (30 - i)) - 64'd1);
        end else begin
          t = '0;
        end
      end
    endcase
    return t;
  endfunction

endpackage

// File: hdl/gcd_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Converts a folded angle in microdegrees to Q30 radians and runs an unrolled
// rotation CORDIC, one iteration per stage.
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [27:0] r_i,
  input  logic        neg_i,
  output logic        valid_o,
  output unit_t       cos_o,
  output unit_t       sin_o
);

  logic [4:0]  vp_q;
  logic [4:0]  np_q;
  logic [59:0] n1_q;
  logic [30:0] q2_q, q3_q, q4_q;
  logic [31:0] nlo2_q, nlo3_q, p3_q, rem4_q;
  logic [30:0] theta_q;
  logic [63:0] qprod;
  logic [31:0] dprod;

  cordic_t     x_q [CORDIC_STEPS];
  cordic_t     y_q [CORDIC_STEPS];
  cordic_t     z_q [CORDIC_STEPS];
  logic        vc_q [CORDIC_STEPS];
  logic        nc_q [CORDIC_STEPS];

  logic        vo_q;
  unit_t       cos_q, sin_q;
  unit_t       cos_sat, sin_sat;

  function automatic unit_t sat_unit(cordic_t v);
    unit_t r;
    if (v > UNIT_POS) begin
      r = unit_t'(UNIT_POS);
    end else if (v < UNIT_NEG) begin
      r = unit_t'(UNIT_NEG);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign qprod = {32'd0, n1_q[59:28]} * {32'd0, RECIP_TURN};
  assign dprod = {1'b0, q2_q} * {3'd0, FULL_TURN};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= '0;
    end else if (en_i) begin
      vp_q <= {vp_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      np_q    <= {np_q[3:0], neg_i};
      n1_q    <= {32'd0, r_i} * {28'd0, PI_Q30};
      q2_q    <= qprod[62:32];
      nlo2_q  <= n1_q[31:0];
      p3_q    <= dprod;
      q3_q    <= q2_q;
      nlo3_q  <= nlo2_q;
      rem4_q  <= nlo3_q - p3_q;
      q4_q    <= q3_q;
      if (rem4_q >= {2'd0, FULL_TURN, 1'b0}) begin
        theta_q <= q4_q + 31'd2;
      end else if (rem4_q >= {3'd0, FULL_TURN}) begin
        theta_q <= q4_q + 31'd1;
      end else begin
        theta_q <= q4_q;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    cordic_t xi, yi, zi;
    logic    vi, ni;
    if (i == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = cordic_t'({3'd0, theta_q});
      assign vi = vp_q[4];
      assign ni = np_q[4];
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign vi = vc_q[i-1];
      assign ni = nc_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[i] <= 1'b0;
      end else if (en_i) begin
        vc_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nc_q[i] <= ni;
        if (!zi[CordicW-1]) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - atan_q30(i);
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + atan_q30(i);
        end
      end
    end
  end

  assign cos_sat = sat_unit(x_q[CORDIC_STEPS-1]);
  assign sin_sat = sat_unit(y_q[CORDIC_STEPS-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vc_q[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= nc_q[CORDIC_STEPS-1] ? -cos_sat : cos_sat;
      sin_q <= sin_sat;
    end
  end

  assign valid_o = vo_q;
  assign cos_o   = cos_q;
  assign sin_o   = sin_q;

endmodule

// File: hdl/gcd_atan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined central angle and distance
// Takes the haversine term, forms both square roots one bit per stage, runs
// an unrolled vectoring CORDIC and scales the angle to meters.
// ----------------------------------------------------------------------------
module gcd_atan import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] a_i,
  output logic        valid_o,
  output logic [24:0] dist_o
);

  logic        v0_q;
  logic [30:0] a0_q, b0_q;

  sqrt_t       sa_q [SqrtSteps];
  sqrt_t       sb_q [SqrtSteps];
  logic [30:0] oa_q [SqrtSteps];
  logic [30:0] ob_q [SqrtSteps];
  logic        vs_q [SqrtSteps];

  cordic_t     x_q [CORDIC_STEPS];
  cordic_t     y_q [CORDIC_STEPS];
  cordic_t     z_q [CORDIC_STEPS];
  logic        vc_q [CORDIC_STEPS];

  logic        vp1_q, vp2_q, vo_q;
  logic [30:0] zc_q;
  logic [24:0] d2_q, dist_q;
  logic [54:0] dprod;
  cordic_t     zf;

  function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
    logic [33:0] rm;
    logic [33:0] tr;
    sqrt_t       nx;
    rm = {cur.rem[31:0], pair};
    tr = {1'b0, cur.root, 2'b01};
    if (rm >= tr) begin
      nx.rem  = rm - tr;
      nx.root = {cur.root[29:0], 1'b1};
    end else begin
      nx.rem  = rm;
      nx.root = {cur.root[29:0], 1'b0};
    end
    return nx;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q <= a_i;
      b0_q <= ONE_Q30 - a_i;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int unsigned K = SqrtSteps - 1 - j;
    sqrt_t       cur_a, cur_b;
    logic [30:0] op_a, op_b;
    logic        vi;
    logic [61:0] na, nb;
    if (j == 0) begin : g_first
      assign cur_a = '0;
      assign cur_b = '0;
      assign op_a  = a0_q;
      assign op_b  = b0_q;
      assign vi    = v0_q;
    end else begin : g_next
      assign cur_a = sa_q[j-1];
      assign cur_b = sb_q[j-1];
      assign op_a  = oa_q[j-1];
      assign op_b  = ob_q[j-1];
      assign vi    = vs_q[j-1];
    end
    assign na = {1'b0, op_a, 30'd0};
    assign nb = {1'b0, op_b, 30'd0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[j] <= 1'b0;
      end else if (en_i) begin
        vs_q[j] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sa_q[j] <= sqrt_step(cur_a, na[2*K+1 -: 2]);
        sb_q[j] <= sqrt_step(cur_b, nb[2*K+1 -: 2]);
        oa_q[j] <= op_a;
        ob_q[j] <= op_b;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    cordic_t xi, yi, zi;
    logic    vi;
    if (i == 0) begin : g_first
      assign xi = cordic_t'({3'd0, sb_q[SqrtSteps-1].root});
      assign yi = cordic_t'({3'd0, sa_q[SqrtSteps-1].root});
      assign zi = '0;
      assign vi = vs_q[SqrtSteps-1];
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign vi = vc_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[i] <= 1'b0;
      end else if (en_i) begin
        vc_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi[CordicW-1]) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - atan_q30(i);
        end else if (yi != '0) begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + atan_q30(i);
        end else begin
          x_q[i] <= xi;
          y_q[i] <= yi;
          z_q[i] <= zi;
        end
      end
    end
  end

  assign zf    = z_q[CORDIC_STEPS-1];
  assign dprod = {24'd0, zc_q} * {31'd0, EARTH_DIAM_M};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vo_q  <= 1'b0;
    end else if (en_i) begin
      vp1_q <= vc_q[CORDIC_STEPS-1];
      vp2_q <= vp1_q;
      vo_q  <= vp2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zf[CordicW-1]) begin
        zc_q <= '0;
      end else if (zf > HALF_PI_C) begin
        zc_q <= HALF_PI_Q30;
      end else begin
        zc_q <= zf[30:0];
      end
      d2_q   <= dprod[54:30];
      dist_q <= (d2_q > DISTANCE_MAX) ? DISTANCE_MAX : d2_q;
    end
  end

  assign valid_o = vo_q;
  assign dist_o  = dist_q;

endmodule

// File: hdl/great_circle_distance.sv
`timescale 1ns / 1ps
// Throughput: one point pair per cycle while the output beat is not held; every stage is a
// register, and the unrolled CORDIC and square-root stages each take one iteration.
// When the output beat is held, the whole pipeline freezes in place.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance between two points given in microdegrees, in meters.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_latitude, first_longitude, second_latitude, second_longitude
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // distance_meters
  output logic [31:0]  m_axis_tdata
);

  logic               en;
  logic signed [27:0] lat1, lat2;
  logic signed [28:0] lon1, lon2;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic signed [29:0] dlat1_q, dlon1_q;
  logic [27:0]        mag1_q, mag2_q;
  logic signed [30:0] wlat2_q, wlon2_q;
  logic [28:0]        ulat3_q, ulon3_q;
  logic [27:0]        rlat4_q, rlon4_q;
  logic [27:0]        cr1_q [3];
  logic [27:0]        cr2_q [3];
  logic [2:0]         cn1_q, cn2_q;

  logic [26:0]        m1f, m2f;
  logic               ng1, ng2;
  logic signed [30:0] wl, wo;

  logic               vsc;
  unit_t              sin_lat, sin_lon, cos1, cos2;
  unit_t              unused_c0, unused_c1, unused_s2, unused_s3;

  logic               t1_q, t2_q, t3_q;
  logic [30:0]        slat1_q, slon1_q, slat2_q, a3_q;
  unit_t              cc1_q, tt2_q;
  logic signed [63:0] sqlat, sqlon, ccp, ttp;
  logic signed [32:0] asum;

  logic               vout;
  logic [24:0]        dist_m;

  assign lat1 = s_axis_tdata[27:0];
  assign lon1 = s_axis_tdata[56:28];
  assign lat2 = s_axis_tdata[84:57];
  assign lon2 = s_axis_tdata[113:85];

  assign en            = !vout || m_axis_tready;
  assign s_axis_tready = en;

  assign ng1 = {1'b0, mag1_q} > QUARTER_TURN;
  assign ng2 = {1'b0, mag2_q} > QUARTER_TURN;
  assign m1f = ng1 ? 27'(HALF_TURN - {1'b0, mag1_q}) : mag1_q[26:0];
  assign m2f = ng2 ? 27'(HALF_TURN - {1'b0, mag2_q}) : mag2_q[26:0];

  always_comb begin
    wl = 31'(dlat1_q);
    wo = 31'(dlon1_q);
    if (dlat1_q < 0) begin
      wl = 31'(dlat1_q) + $signed({2'b0, FULL_TURN});
    end else if (31'(dlat1_q) >= $signed({2'b0, FULL_TURN})) begin
      wl = 31'(dlat1_q) - $signed({2'b0, FULL_TURN});
    end
    if (dlon1_q < 0) begin
      wo = 31'(dlon1_q) + $signed({2'b0, FULL_TURN});
    end else if (31'(dlon1_q) >= $signed({2'b0, FULL_TURN})) begin
      wo = 31'(dlon1_q) - $signed({2'b0, FULL_TURN});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      t1_q <= 1'b0;
      t2_q <= 1'b0;
      t3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      t1_q <= vsc;
      t2_q <= t1_q;
      t3_q <= t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat1_q <= 30'(lat2) - 30'(lat1);
      dlon1_q <= 30'(lon2) - 30'(lon1);
      mag1_q  <= lat1[27] ? 28'(-29'(lat1)) : 28'(lat1);
      mag2_q  <= lat2[27] ? 28'(-29'(lat2)) : 28'(lat2);

      wlat2_q  <= wl;
      wlon2_q  <= wo;
      cr1_q[0] <= {m1f, 1'b0};
      cr2_q[0] <= {m2f, 1'b0};
      cn1_q[0] <= ng1;
      cn2_q[0] <= ng2;

      ulat3_q  <= wlat2_q[30] ? 29'(wlat2_q + $signed({2'b0, FULL_TURN})) : wlat2_q[28:0];
      ulon3_q  <= wlon2_q[30] ? 29'(wlon2_q + $signed({2'b0, FULL_TURN})) : wlon2_q[28:0];
      cr1_q[1] <= cr1_q[0];
      cr2_q[1] <= cr2_q[0];
      cn1_q[1] <= cn1_q[0];
      cn2_q[1] <= cn2_q[0];

      rlat4_q  <= (ulat3_q > HALF_TURN) ? 28'(FULL_TURN - ulat3_q) : ulat3_q[27:0];
      rlon4_q  <= (ulon3_q > HALF_TURN) ? 28'(FULL_TURN - ulon3_q) : ulon3_q[27:0];
      cr1_q[2] <= cr1_q[1];
      cr2_q[2] <= cr2_q[1];
      cn1_q[2] <= cn1_q[1];
      cn2_q[2] <= cn2_q[1];
    end
  end

  gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .r_i(rlat4_q), .neg_i(1'b0),
    .valid_o(vsc), .cos_o(unused_c0), .sin_o(sin_lat)
  );

  gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .r_i(rlon4_q), .neg_i(1'b0),
    .valid_o(), .cos_o(unused_c1), .sin_o(sin_lon)
  );

  gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_c1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .r_i(cr1_q[2]), .neg_i(cn1_q[2]),
    .valid_o(), .cos_o(cos1), .sin_o(unused_s2)
  );

  gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_c2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .r_i(cr2_q[2]), .neg_i(cn2_q[2]),
    .valid_o(), .cos_o(cos2), .sin_o(unused_s3)
  );

  assign sqlat = sin_lat * sin_lat;
  assign sqlon = sin_lon * sin_lon;
  assign ccp   = cos1 * cos2;
  assign ttp   = cc1_q * $signed({1'b0, slon1_q});
  assign asum  = $signed({2'b0, slat2_q}) + $signed({tt2_q[31], tt2_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      slat1_q <= sqlat[60:30];
      slon1_q <= sqlon[60:30];
      cc1_q   <= ccp[61:30];

      tt2_q   <= ttp[61:30];
      slat2_q <= slat1_q;

      if (asum[32]) begin
        a3_q <= '0;
      end else if (asum > $signed({2'b0, ONE_Q30})) begin
        a3_q <= ONE_Q30;
      end else begin
        a3_q <= asum[30:0];
      end
    end
  end

  gcd_atan #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan (
    .clk_i, .rst_ni, .en_i(en), .valid_i(t3_q), .a_i(a3_q),
    .valid_o(vout), .dist_o(dist_m)
  );

  assign m_axis_tvalid = vout;
  assign m_axis_tdata  = {7'd0, dist_m};

endmodule
